// ===== rtl/core/dtw_pkg.sv =====
package dtw_pkg;

    // Depth of the container stack, counting the message budget at level 0.
    localparam int MAX_DEPTH = 8;
    // Width of a per-level byte budget.
    localparam int LEN_BITS = 16;

    // Fixed field widths of the channels.
    localparam int MSG_LEN_W = 16;
    localparam int BYTE_W    = 8;
    localparam int INDEX_W   = 32;

    // Largest budget a level can hold, used to saturate the message length.
    localparam logic [31:0] LEN_LIMIT = 32'((64'd1 << LEN_BITS) - 64'd1);

    // Tag codes understood by the walker.
    localparam logic [BYTE_W-1:0] TAG_SKIP      = 8'h00;
    localparam logic [BYTE_W-1:0] TAG_INTEGER   = 8'h02;
    localparam logic [BYTE_W-1:0] TAG_BITSTRING = 8'h03;
    localparam logic [BYTE_W-1:0] TAG_NULL      = 8'h05;
    localparam logic [BYTE_W-1:0] TAG_OID       = 8'h06;
    localparam logic [BYTE_W-1:0] TAG_SEQUENCE  = 8'h30;

    // Short-form lengths stay below this value.
    localparam logic [BYTE_W-1:0] LEN_LONG_FORM = 8'h80;

    typedef logic [LEN_BITS-1:0] t_len;

    // Command broadcast from the control logic to every level cell.
    typedef struct packed {
        logic clear;     // drop all levels
        logic start;     // open level 0 with start_len
        t_len start_len;
        logic push;      // open the next level above the top
        t_len push_len;
        logic wr_top;    // overwrite the budget of the top level
        t_len wr_val;
        logic pop_en;    // close finished levels from the top down
    } t_lvl_cmd;

    // One result transaction.
    typedef struct packed {
        logic [INDEX_W-1:0] item_index;
        logic               item_type;
        logic [BYTE_W-1:0]  content_byte;
        logic               byte_present;
        logic               last_of_item;
        logic               parse_error;
    } t_result;

endpackage

// ===== rtl/core/dtw_stream_if.sv =====
// Input channel: start items and message bytes.
interface dtw_msg_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [dtw_pkg::MSG_LEN_W-1:0] message_length;
    logic [dtw_pkg::BYTE_W-1:0]    data_byte;

    modport source (output valid, output kind, output message_length, output data_byte,
                    input ready);
    modport sink (input valid, input kind, input message_length, input data_byte,
                  output ready);
endinterface

// Output channel: content bytes, empty marks and error reports.
interface dtw_item_if;
    logic                        valid;
    logic                        ready;
    logic [dtw_pkg::INDEX_W-1:0] item_index;
    logic                        item_type;
    logic [dtw_pkg::BYTE_W-1:0]  content_byte;
    logic                        byte_present;
    logic                        last_of_item;
    logic                        parse_error;

    modport source (output valid, output item_index, output item_type, output content_byte,
                    output byte_present, output last_of_item, output parse_error,
                    input ready);
    modport sink (input valid, input item_index, input item_type, input content_byte,
                  input byte_present, input last_of_item, input parse_error,
                  output ready);
endinterface

// ===== rtl/core/dtw_level_cell.sv =====
module dtw_level_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dtw_pkg::t_lvl_cmd i_cmd,
    input  logic              i_base,
    input  logic              i_valid_below,
    input  logic              i_valid_above,
    input  dtw_pkg::t_len     i_top_rem_below,
    output dtw_pkg::t_len     o_top_rem,
    input  logic              i_gone_above,
    output logic              o_gone,
    output logic              o_valid,
    output logic              o_stays
);

    logic          r_valid;
    logic          n_valid;
    dtw_pkg::t_len r_rem;
    dtw_pkg::t_len n_rem;
    dtw_pkg::t_len w_rem_after;
    logic          w_is_top;
    logic          w_is_slot;
    logic          w_done;

    // This cell is the top of the stack, or the free slot right above it.
    assign w_is_top  = r_valid && !i_valid_above;
    assign w_is_slot = i_valid_below && !r_valid;

    // Budget as it stands after this transaction's write to the top.
    assign w_rem_after = (w_is_top && i_cmd.wr_top) ? i_cmd.wr_val : r_rem;
    assign w_done      = !i_base && (w_rem_after == '0);

    // Pass the top budget upward and the closing sweep downward.
    assign o_top_rem = r_valid ? r_rem : i_top_rem_below;
    assign o_gone    = i_gone_above && (!r_valid || w_done);
    assign o_valid   = r_valid;
    assign o_stays   = n_valid;

    // Next level state.
    always_comb begin
        n_valid = r_valid;
        n_rem   = w_rem_after;
        if (i_cmd.clear) begin
            n_valid = 1'b0;
        end else if (i_cmd.start) begin
            n_valid = i_base;
            n_rem   = i_cmd.start_len;
        end else if (i_cmd.push && w_is_slot) begin
            n_valid = 1'b1;
            n_rem   = i_cmd.push_len;
        end else if (i_cmd.pop_en && i_gone_above && r_valid && w_done) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_rem <= n_rem;
    end

endmodule

// ===== rtl/core/dtw_out_skid.sv =====
module dtw_out_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dtw_pkg::t_result i_data,
    output logic             o_space,
    output logic             o_valid,
    output dtw_pkg::t_result o_data,
    input  logic             i_ready
);

    logic             r_out_valid;
    dtw_pkg::t_result r_out;
    logic             r_skid_valid;
    dtw_pkg::t_result r_skid;
    logic             w_out_free;

    assign o_space    = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;
    assign w_out_free = !r_out_valid || i_ready;

    // Output register with one skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_push) begin
                r_out <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

// ===== rtl/core/der_tlv_walker_unit.sv =====
// Streaming walker for one top-level DER node with short-form lengths.
// i_msg carries start transactions (kind 0, with the message length) and
// message bytes (kind 1). o_item carries INTEGER and OID content bytes with
// a running item index, empty marks for zero-length INTEGER and OID items, and
// error reports. The block takes one transaction per cycle while i_msg.ready
// is high; each result is registered before it appears on o_item. The level
// stack is a row of cells, one per level, and the budget update plus the
// closing of finished containers is settled combinationally for each byte.
// The output has a register and one skid entry: while o_item is stalled the
// block keeps taking transactions until a second result lands in the skid
// entry, then holds i_msg.ready low until the receiver takes the waiting one.
// After an error, or once the top node ends, bytes are dropped without result
// until the next start transaction. A start abandons any walk in progress;
// the item index keeps counting across messages.
// Reset clears the stack, the walk state, the item index and both output
// entries; the block is ready for transactions as soon as reset is released.
module der_tlv_walker_unit (
    input logic       i_clk,
    input logic       i_rst_n,
    dtw_msg_if.sink   i_msg,
    dtw_item_if.source o_item
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TAG,
        PH_LEN,
        PH_CONTENT
    } t_phase;

    localparam int MD = dtw_pkg::MAX_DEPTH;

    t_phase                          r_phase;
    t_phase                          w_phase_pre;
    t_phase                          n_phase;
    logic [dtw_pkg::BYTE_W-1:0]      r_tag;
    logic [dtw_pkg::BYTE_W-1:0]      n_tag;
    logic [dtw_pkg::BYTE_W-1:0]      r_left;
    logic [dtw_pkg::BYTE_W-1:0]      n_left;
    logic [dtw_pkg::INDEX_W-1:0]     r_found;
    logic [dtw_pkg::INDEX_W-1:0]     n_found;

    dtw_pkg::t_lvl_cmd               w_cmd;
    dtw_pkg::t_result                w_res;
    logic                            w_has_res;
    logic                            w_node_done;
    logic                            w_fire;
    logic                            w_space;
    logic [31:0]                     w_len_ext;
    dtw_pkg::t_len                   w_len_sat;
    dtw_pkg::t_len                   w_byte_ext;
    dtw_pkg::t_len                   w_top_rem;
    logic                            w_full;
    logic                            w_is_item;
    logic                            w_is_cont;

    logic [MD-1:0]                   w_valid;
    logic                            w_valid_ext [MD:0];
    logic                            w_vbelow [MD-1:0];
    dtw_pkg::t_len                   w_rem_chain [MD:0];
    logic                            w_gone [MD:0];
    logic                            w_stays [MD:0];
    dtw_pkg::t_result                w_out_data;

    assign w_fire = i_msg.valid && i_msg.ready;
    assign i_msg.ready = w_space;

    // Saturate the message length into a level budget.
    assign w_len_ext  = 32'(i_msg.message_length);
    assign w_len_sat  = (w_len_ext > dtw_pkg::LEN_LIMIT) ? dtw_pkg::LEN_LIMIT[dtw_pkg::LEN_BITS-1:0]
                                                         : w_len_ext[dtw_pkg::LEN_BITS-1:0];
    assign w_byte_ext = dtw_pkg::LEN_BITS'(i_msg.data_byte);

    assign w_top_rem = w_rem_chain[MD];
    assign w_full    = w_valid[MD-1];
    assign w_is_item = (r_tag == dtw_pkg::TAG_INTEGER) || (r_tag == dtw_pkg::TAG_OID);
    assign w_is_cont = (r_tag == dtw_pkg::TAG_SEQUENCE) || (r_tag == dtw_pkg::TAG_BITSTRING);

    // Chain boundaries.
    assign w_rem_chain[0]  = '0;
    assign w_gone[MD]      = 1'b1;
    assign w_stays[MD]     = 1'b0;
    assign w_valid_ext[MD] = 1'b0;
    assign w_vbelow[0]     = 1'b1;

    // Row of level cells; cell 0 holds the message budget.
    for (genvar g = 0; g < MD; g++) begin : g_level
        if (g > 0) begin : g_below
            assign w_vbelow[g] = w_valid_ext[g-1];
        end
        assign w_valid[g] = w_valid_ext[g];

        dtw_level_cell u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_cmd           (w_cmd),
            .i_base          (1'(g == 0)),
            .i_valid_below   (w_vbelow[g]),
            .i_valid_above   (w_valid_ext[g+1]),
            .i_top_rem_below (w_rem_chain[g]),
            .o_top_rem       (w_rem_chain[g+1]),
            .i_gone_above    (w_gone[g+1]),
            .o_gone          (w_gone[g]),
            .o_valid         (w_valid_ext[g]),
            .o_stays         (w_stays[g])
        );
    end

    // Decode one transaction against the walk state.
    always_comb begin
        w_cmd       = '0;
        w_res       = '0;
        w_has_res   = 1'b0;
        w_node_done = 1'b0;
        w_phase_pre = r_phase;
        n_tag       = r_tag;
        n_left      = r_left;
        n_found     = r_found;
        if (w_fire) begin
            if (!i_msg.kind) begin
                n_tag  = '0;
                n_left = '0;
                if (w_len_sat == '0) begin
                    w_cmd.clear       = 1'b1;
                    w_phase_pre       = PH_IDLE;
                    w_has_res         = 1'b1;
                    w_res.parse_error = 1'b1;
                end else begin
                    w_cmd.start     = 1'b1;
                    w_cmd.start_len = w_len_sat;
                    w_phase_pre     = PH_TAG;
                end
            end else begin
                case (r_phase)
                    PH_IDLE: begin
                    end
                    PH_CONTENT: begin
                        if (r_left <= 8'd1) begin
                            n_left      = '0;
                            w_node_done = 1'b1;
                            if (w_is_item) begin
                                n_found = r_found + dtw_pkg::INDEX_W'(1);
                            end
                        end else begin
                            n_left = r_left - 8'd1;
                        end
                        if (w_is_item) begin
                            w_has_res          = 1'b1;
                            w_res.item_index   = r_found;
                            w_res.item_type    = (r_tag == dtw_pkg::TAG_OID);
                            w_res.content_byte = i_msg.data_byte;
                            w_res.byte_present = 1'b1;
                            w_res.last_of_item = (r_left <= 8'd1);
                        end
                    end
                    PH_TAG: begin
                        if (i_msg.data_byte == dtw_pkg::TAG_SKIP) begin
                            if (w_top_rem == '0) begin
                                w_cmd.clear       = 1'b1;
                                w_phase_pre       = PH_IDLE;
                                w_has_res         = 1'b1;
                                w_res.parse_error = 1'b1;
                            end else begin
                                w_cmd.wr_top = 1'b1;
                                w_cmd.wr_val = w_top_rem - dtw_pkg::LEN_BITS'(1);
                                w_node_done  = 1'b1;
                            end
                        end else if (i_msg.data_byte inside {dtw_pkg::TAG_SEQUENCE,
                                                             dtw_pkg::TAG_BITSTRING,
                                                             dtw_pkg::TAG_INTEGER,
                                                             dtw_pkg::TAG_OID,
                                                             dtw_pkg::TAG_NULL}) begin
                            if (w_top_rem < dtw_pkg::LEN_BITS'(2)) begin
                                w_cmd.clear       = 1'b1;
                                w_phase_pre       = PH_IDLE;
                                w_has_res         = 1'b1;
                                w_res.parse_error = 1'b1;
                            end else begin
                                n_tag       = i_msg.data_byte;
                                w_phase_pre = PH_LEN;
                            end
                        end else begin
                            w_cmd.clear       = 1'b1;
                            w_phase_pre       = PH_IDLE;
                            w_has_res         = 1'b1;
                            w_res.parse_error = 1'b1;
                        end
                    end
                    PH_LEN: begin
                        if ((i_msg.data_byte >= dtw_pkg::LEN_LONG_FORM)
                            || (w_top_rem < dtw_pkg::LEN_BITS'(2))
                            || (w_byte_ext > w_top_rem - dtw_pkg::LEN_BITS'(2))) begin
                            w_cmd.clear       = 1'b1;
                            w_phase_pre       = PH_IDLE;
                            w_has_res         = 1'b1;
                            w_res.parse_error = 1'b1;
                        end else if (w_is_cont) begin
                            if ((i_msg.data_byte < 8'd2) || w_full) begin
                                w_cmd.clear       = 1'b1;
                                w_phase_pre       = PH_IDLE;
                                w_has_res         = 1'b1;
                                w_res.parse_error = 1'b1;
                            end else begin
                                w_cmd.wr_top   = 1'b1;
                                w_cmd.wr_val   = w_top_rem - dtw_pkg::LEN_BITS'(2) - w_byte_ext;
                                w_cmd.push     = 1'b1;
                                w_cmd.push_len = w_byte_ext;
                                w_phase_pre    = PH_TAG;
                            end
                        end else begin
                            w_cmd.wr_top = 1'b1;
                            w_cmd.wr_val = w_top_rem - dtw_pkg::LEN_BITS'(2) - w_byte_ext;
                            if (i_msg.data_byte == '0) begin
                                w_node_done = 1'b1;
                                if (w_is_item) begin
                                    n_found            = r_found + dtw_pkg::INDEX_W'(1);
                                    w_has_res          = 1'b1;
                                    w_res.item_index   = r_found;
                                    w_res.item_type    = (r_tag == dtw_pkg::TAG_OID);
                                    w_res.last_of_item = 1'b1;
                                end
                            end else begin
                                n_left      = i_msg.data_byte;
                                w_phase_pre = PH_CONTENT;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        w_cmd.pop_en = w_node_done;
    end

    // A finished node returns to tag parsing only while a container stays open.
    assign n_phase = w_node_done ? (w_stays[1] ? PH_TAG : PH_IDLE) : w_phase_pre;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tag   <= '0;
            r_left  <= '0;
            r_found <= '0;
        end else begin
            r_phase <= n_phase;
            r_tag   <= n_tag;
            r_left  <= n_left;
            r_found <= n_found;
        end
    end

    // Result register and skid entry.
    dtw_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_has_res),
        .i_data  (w_res),
        .o_space (w_space),
        .o_valid (o_item.valid),
        .o_data  (w_out_data),
        .i_ready (o_item.ready)
    );

    assign o_item.item_index   = w_out_data.item_index;
    assign o_item.item_type    = w_out_data.item_type;
    assign o_item.content_byte = w_out_data.content_byte;
    assign o_item.byte_present = w_out_data.byte_present;
    assign o_item.last_of_item = w_out_data.last_of_item;
    assign o_item.parse_error  = w_out_data.parse_error;

    // Open levels always form a contiguous run from level 0.
    a_levels_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + MD'(1))) == '0)
        else $error("level stack has a gap");

    // A walk in progress always has the message budget open.
    a_walk_has_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> w_valid[0])
        else $error("walk active without level 0");

    // Content phase always has bytes to come.
    a_content_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CONTENT) |-> (r_left != '0))
        else $error("content phase with nothing left");

    // Back-pressure on the input only comes from a waiting result.
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_msg.ready |-> o_item.valid)
        else $error("input stalled with no result pending");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

    // Transaction kinds on the message channel.
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_BYTE  = 1'b1;

    // Item type codes on the result channel.
    localparam logic ITEM_INTEGER = 1'b0;
    localparam logic ITEM_OID     = 1'b1;

    localparam int ITEM_TARGET  = 850;
    localparam int TAIL_ITEMS   = 120;
    localparam int LONG_HOLD    = 64;
    localparam int HOLD_AFTER   = 60;
    localparam int DRAIN_CYCLES = 20;
    localparam int SETTLE_LIMIT = 5000;
    localparam int TIMEOUT_NS   = 4_000_000;
    localparam int REPORT_LIMIT = 10;

    typedef enum logic [1:0] {WALK_IDLE, WALK_TAG, WALK_LEN, WALK_CONTENT} t_walk;

    typedef struct packed {
        logic                          kind;
        logic [dtw_pkg::MSG_LEN_W-1:0] msg_len;
        logic [dtw_pkg::BYTE_W-1:0]    data;
    } t_msg_xact;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    dtw_msg_if  msg_if ();
    dtw_item_if item_if ();

    der_tlv_walker_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_msg   (msg_if),
        .o_item  (item_if)
    );

    // Clock generation.
    always #4 clk = ~clk;

    // Signals driven into the block, all known from time zero.
    logic                          drv_valid = 1'b0;
    logic                          drv_kind  = KIND_START;
    logic [dtw_pkg::MSG_LEN_W-1:0] drv_len   = '0;
    logic [dtw_pkg::BYTE_W-1:0]    drv_byte  = '0;
    logic                          drv_ready = 1'b0;

    assign msg_if.valid          = drv_valid;
    assign msg_if.kind           = drv_kind;
    assign msg_if.message_length = drv_len;
    assign msg_if.data_byte      = drv_byte;
    assign item_if.ready         = drv_ready;

    t_msg_xact          msg_backlog[$];
    dtw_pkg::t_result   due_results[$];
    logic [7:0]         node_bytes[$];

    logic quiet_tail = 1'b0;
    int   send_gap = 0;
    int   sent_count = 0;
    int   message_count = 0;
    int   results_checked = 0;
    int   error_reports = 0;
    int   empty_marks = 0;
    int   fail_count = 0;

    // Walker state as the block should hold it.
    dtw_pkg::t_len level_left [dtw_pkg::MAX_DEPTH] = '{default: '0};
    logic [3:0]    levels_open = '0;
    t_walk         walk_phase  = WALK_IDLE;
    logic [7:0]    node_tag    = '0;
    logic [7:0]    body_left   = '0;
    logic [31:0]   items_found = '0;

    // Error report: the walk stops and every other field is zero.
    function automatic bit flag_error(output dtw_pkg::t_result res);
        walk_phase  = WALK_IDLE;
        levels_open = '0;
        res = '0;
        res.parse_error = 1'b1;
        return 1'b1;
    endfunction

    // Close every container whose budget is used up, then pick the next phase.
    function automatic void close_finished();
        while (levels_open > 1 && level_left[levels_open - 1] == '0)
            levels_open--;
        walk_phase = (levels_open <= 1) ? WALK_IDLE : WALK_TAG;
    endfunction

    // Advance the walk by one transaction; returns 1 when a result is due.
    function automatic bit walk_predict(input logic kind,
                                        input logic [dtw_pkg::MSG_LEN_W-1:0] msg_len,
                                        input logic [dtw_pkg::BYTE_W-1:0] b,
                                        output dtw_pkg::t_result res);
        int unsigned lvl;
        int unsigned room;
        logic        is_item;
        logic        last;
        logic [31:0] idx;
        res = '0;

        // A start abandons any walk and loads the message budget.
        if (kind == KIND_START) begin
            level_left[0] = (32'(msg_len) > dtw_pkg::LEN_LIMIT)
                            ? dtw_pkg::t_len'(dtw_pkg::LEN_LIMIT)
                            : dtw_pkg::t_len'(msg_len);
            levels_open = 4'd1;
            node_tag    = '0;
            body_left   = '0;
            if (msg_len == '0)
                return flag_error(res);
            walk_phase = WALK_TAG;
            return 1'b0;
        end

        if (walk_phase == WALK_IDLE)
            return 1'b0;

        is_item = (node_tag == dtw_pkg::TAG_INTEGER) || (node_tag == dtw_pkg::TAG_OID);

        // Content bytes: only INTEGER and OID content is passed on.
        if (walk_phase == WALK_CONTENT) begin
            last = (body_left <= 8'd1);
            idx  = items_found;
            body_left = last ? 8'd0 : body_left - 8'd1;
            if (last) begin
                if (is_item)
                    items_found++;
                close_finished();
            end
            if (!is_item)
                return 1'b0;
            res.item_index   = idx;
            res.item_type    = (node_tag == dtw_pkg::TAG_OID) ? ITEM_OID : ITEM_INTEGER;
            res.content_byte = b;
            res.byte_present = 1'b1;
            res.last_of_item = last;
            return 1'b1;
        end

        if (levels_open == 0 || levels_open > dtw_pkg::MAX_DEPTH)
            return flag_error(res);
        lvl  = levels_open - 1;
        room = level_left[lvl];

        // Tag byte.
        if (walk_phase == WALK_TAG) begin
            if (b == dtw_pkg::TAG_SKIP) begin
                if (room < 1)
                    return flag_error(res);
                level_left[lvl] = dtw_pkg::t_len'(room - 1);
                close_finished();
                return 1'b0;
            end
            if (b == dtw_pkg::TAG_SEQUENCE || b == dtw_pkg::TAG_BITSTRING ||
                b == dtw_pkg::TAG_INTEGER || b == dtw_pkg::TAG_OID ||
                b == dtw_pkg::TAG_NULL) begin
                if (room < 2)
                    return flag_error(res);
                node_tag   = b;
                walk_phase = WALK_LEN;
                return 1'b0;
            end
            return flag_error(res);
        end

        // Length byte: short form only, and it must fit in the parent.
        if (b >= dtw_pkg::LEN_LONG_FORM || room < 2 || int'(b) > room - 2)
            return flag_error(res);
        level_left[lvl] = dtw_pkg::t_len'(room - 2 - b);

        if (node_tag == dtw_pkg::TAG_SEQUENCE || node_tag == dtw_pkg::TAG_BITSTRING) begin
            if (b < 2 || levels_open >= dtw_pkg::MAX_DEPTH)
                return flag_error(res);
            level_left[levels_open] = dtw_pkg::t_len'(b);
            levels_open++;
            walk_phase = WALK_TAG;
            return 1'b0;
        end
        if (b == '0) begin
            if (is_item) begin
                res.item_index   = items_found;
                res.item_type    = (node_tag == dtw_pkg::TAG_OID) ? ITEM_OID : ITEM_INTEGER;
                res.last_of_item = 1'b1;
                items_found++;
                close_finished();
                return 1'b1;
            end
            close_finished();
            return 1'b0;
        end
        body_left  = b;
        walk_phase = WALK_CONTENT;
        return 1'b0;
    endfunction

    // Stimulus helpers; the unused field of each transaction is random.
    function automatic void queue_start(input int len);
        t_msg_xact x;
        x.kind    = KIND_START;
        x.msg_len = dtw_pkg::MSG_LEN_W'(len);
        x.data    = dtw_pkg::BYTE_W'($urandom);
        msg_backlog = {msg_backlog, x};
        message_count++;
    endfunction

    function automatic void queue_byte(input logic [dtw_pkg::BYTE_W-1:0] b);
        t_msg_xact x;
        x.kind    = KIND_BYTE;
        x.msg_len = dtw_pkg::MSG_LEN_W'($urandom);
        x.data    = b;
        msg_backlog = {msg_backlog, x};
    endfunction

    // Append one byte to the node under construction.
    function automatic void add_node_byte(input logic [7:0] b);
        node_bytes = {node_bytes, b};
    endfunction

    // Short-form length, mostly small.
    function automatic int pick_length(input int lo, input int hi);
        int cap;
        cap = (hi > 127) ? 127 : hi;
        if (cap <= lo)
            return lo;
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(lo, (lo + 6 < cap) ? lo + 6 : cap);
        return $urandom_range(lo, cap);
    endfunction

    // Append one well-formed node of at most room bytes to node_bytes; returns its size.
    function automatic int build_node(input int depth, input int room);
        int pick;
        int body;
        int used;
        pick = $urandom_range(0, 99);
        if (room < 2 || pick < 8) begin
            add_node_byte(dtw_pkg::TAG_SKIP);
            return 1;
        end
        // Containers are nested only as deep as the stack allows.
        if (room >= 4 && depth <= dtw_pkg::MAX_DEPTH - 2 && pick < 38) begin
            body = pick_length(2, room - 2);
            add_node_byte((pick < 28) ? dtw_pkg::TAG_SEQUENCE : dtw_pkg::TAG_BITSTRING);
            add_node_byte(8'(body));
            used = 0;
            while (used < body)
                used += build_node(depth + 1, body - used);
            return body + 2;
        end
        if (pick < 48)
            add_node_byte(dtw_pkg::TAG_NULL);
        else if (pick < 74)
            add_node_byte(dtw_pkg::TAG_INTEGER);
        else
            add_node_byte(dtw_pkg::TAG_OID);
        body = pick_length(0, room - 2);
        add_node_byte(8'(body));
        for (int i = 0; i < body; i++)
            add_node_byte(8'($urandom));
        return body + 2;
    endfunction

    function automatic void report_mismatch(input string what, input dtw_pkg::t_result want,
                                            input dtw_pkg::t_result got);
        if (fail_count < REPORT_LIMIT)
            $display("[%0t] %s: expected idx=%0d type=%0d byte=%02h present=%0b last=%0b",
                     $realtime, what,
                     want.item_index, want.item_type, want.content_byte,
                     want.byte_present, want.last_of_item,
                     " err=%0b, got idx=%0d type=%0d byte=%02h present=%0b last=%0b err=%0b",
                     want.parse_error,
                     got.item_index, got.item_type, got.content_byte,
                     got.byte_present, got.last_of_item, got.parse_error);
        fail_count++;
    endfunction

    // Driver: offers the backlog one transaction at a time, with random gaps.
    always @(posedge clk) begin
        t_msg_xact nxt;
        if (!rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            quiet_tail <= (msg_backlog.size() <= TAIL_ITEMS);
            if (drv_valid && msg_if.ready)
                sent_count++;
            if (!drv_valid || msg_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    drv_valid <= 1'b0;
                end else if (msg_backlog.size() > 0) begin
                    nxt = msg_backlog.pop_front();
                    drv_valid <= 1'b1;
                    drv_kind  <= nxt.kind;
                    drv_len   <= nxt.msg_len;
                    drv_byte  <= nxt.data;
                    if (!quiet_tail && $urandom_range(0, 99) < 15)
                        send_gap = $urandom_range(1, 12);
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off once results flow.
    always @(posedge clk) begin : result_sink
        int stall_left;
        int hold_left;
        int seen;
        bit hold_done;
        if (!rst_n) begin
            drv_ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
            seen       = 0;
            hold_done  = 1'b0;
        end else begin
            if (item_if.valid && drv_ready)
                seen++;
            if (hold_left > 0) begin
                hold_left--;
                drv_ready <= 1'b0;
            end else if (!hold_done && seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                drv_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                drv_ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 99) < 12) begin
                stall_left = $urandom_range(1, 12) - 1;
                drv_ready <= 1'b0;
            end else begin
                drv_ready <= 1'b1;
            end
        end
    end

    // Monitor: predicts on every accepted input and checks every accepted result.
    always @(posedge clk) begin
        dtw_pkg::t_result predicted;
        dtw_pkg::t_result got;
        dtw_pkg::t_result want;
        if (rst_n) begin
            if (msg_if.valid && msg_if.ready) begin
                if (walk_predict(msg_if.kind, msg_if.message_length, msg_if.data_byte,
                                 predicted))
                    due_results = {due_results, predicted};
            end
            if (item_if.valid && item_if.ready) begin
                got.item_index   = item_if.item_index;
                got.item_type    = item_if.item_type;
                got.content_byte = item_if.content_byte;
                got.byte_present = item_if.byte_present;
                got.last_of_item = item_if.last_of_item;
                got.parse_error  = item_if.parse_error;
                results_checked++;
                if (got.parse_error)
                    error_reports++;
                else if (!got.byte_present)
                    empty_marks++;
                if (due_results.size() == 0) begin
                    report_mismatch("unexpected result", '0, got);
                end else begin
                    want = due_results.pop_front();
                    if (got.item_index !== want.item_index ||
                        got.item_type !== want.item_type ||
                        got.content_byte !== want.content_byte ||
                        got.byte_present !== want.byte_present ||
                        got.last_of_item !== want.last_of_item ||
                        got.parse_error !== want.parse_error)
                        report_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    // Overall time limit.
    initial begin
        #(TIMEOUT_NS);
        $display("der_tlv_walker_unit verification failed");
        $finish;
    end

    // Stimulus generation and end of run.
    initial begin
        int style;
        int room;
        int n;
        int len;
        int cut;
        int variant;
        int wait_cycles;

        // Directed part.
        queue_byte(8'hFF);                      // byte while idle
        queue_start(0);                         // empty message
        queue_start(65535);
        queue_byte(dtw_pkg::TAG_SEQUENCE);  queue_byte(8'h0B);
        queue_byte(dtw_pkg::TAG_INTEGER);   queue_byte(8'h00);          // empty integer
        queue_byte(dtw_pkg::TAG_OID);       queue_byte(8'h01); queue_byte(8'hFF);
        queue_byte(dtw_pkg::TAG_NULL);      queue_byte(8'h00);
        queue_byte(dtw_pkg::TAG_SKIP);
        queue_byte(dtw_pkg::TAG_INTEGER);   queue_byte(8'h7F);          // longer than parent
        queue_start(1);
        queue_byte(dtw_pkg::TAG_INTEGER);                                // header does not fit
        queue_start(3);
        queue_byte(dtw_pkg::TAG_BITSTRING); queue_byte(dtw_pkg::LEN_LONG_FORM); // long form
        queue_start(4);
        queue_byte(dtw_pkg::TAG_SEQUENCE);  queue_byte(8'h01);          // container too small
        queue_start(2);
        queue_byte(8'h17);                                               // unknown tag

        // Random part: mostly well-formed messages, some broken ones and noise.
        while (msg_backlog.size() < ITEM_TARGET) begin
            style = $urandom_range(0, 99);
            node_bytes.delete();
            if (style < 7) begin
                // Nest containers until the stack overflows.
                queue_start(2 * dtw_pkg::MAX_DEPTH + 2);
                for (int d = 0; d < dtw_pkg::MAX_DEPTH - 1; d++) begin
                    queue_byte($urandom_range(0, 1) ? dtw_pkg::TAG_SEQUENCE
                                                    : dtw_pkg::TAG_BITSTRING);
                    queue_byte(8'(2 * dtw_pkg::MAX_DEPTH - 2 * d));
                end
                queue_byte(dtw_pkg::TAG_BITSTRING);
                queue_byte(8'd2);
            end else if (style < 15) begin
                // Noise: arbitrary length and arbitrary bytes.
                queue_start(($urandom_range(0, 1) != 0) ? $urandom_range(0, 65535)
                                                        : $urandom_range(0, 8));
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    queue_byte(8'($urandom));
            end else begin
                room = ($urandom_range(0, 99) < 10) ? $urandom_range(40, 140)
                                                     : $urandom_range(2, 30);
                n = build_node(0, room);
                variant = $urandom_range(0, 99);
                if (variant < 10)
                    len = (n > 1) ? $urandom_range(1, n - 1) : n;   // budget too small
                else if (variant < 22)
                    len = n + $urandom_range(1, 3);                 // trailing bytes
                else if (variant < 28)
                    len = $urandom_range(n, 65535);
                else
                    len = n;
                queue_start(len);
                if (variant >= 30 && variant < 38)
                    node_bytes[$urandom_range(0, n - 1)] = 8'($urandom);  // corrupted byte
                cut = n;
                if (variant >= 38 && variant < 46 && n > 1)
                    cut = $urandom_range(1, n - 1);                 // abandoned by next start
                for (int i = 0; i < cut; i++)
                    queue_byte(node_bytes[i]);
                if ((variant >= 10 && variant < 22) || $urandom_range(0, 99) < 15) begin
                    n = $urandom_range(1, 3);
                    for (int i = 0; i < n; i++)
                        queue_byte(8'($urandom));
                end
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the backlog to drain, then for every expected result.
        while (msg_backlog.size() > 0 || drv_valid)
            @(posedge clk);
        wait_cycles = 0;
        while (due_results.size() > 0 && wait_cycles < SETTLE_LIMIT) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (due_results.size() > 0) begin
            $display("%0d expected results never arrived", due_results.size());
            fail_count += due_results.size();
        end

        $display("Walked %0d messages in %0d input transactions; checked %0d results",
                 message_count, sent_count, results_checked);
        $display("including %0d error reports and %0d empty item marks, %0d failures.",
                 error_reports, empty_marks, fail_count);
        if (fail_count == 0)
            $display("der_tlv_walker_unit verification clean");
        else
            $display("der_tlv_walker_unit verification failed");
        $finish;
    end

endmodule
